@@ rtl/core/link_data_frame_deframer_unit_defines.svh @@
// Assertion macros shared by the deframer RTL.
// Each macro checks on the rising edge of clk and is disabled while arst_n is low.
`ifndef LINK_DATA_FRAME_DEFRAMER_UNIT_DEFINES_SVH
`define LINK_DATA_FRAME_DEFRAMER_UNIT_DEFINES_SVH

// The condition must hold at every clock edge.
`define LDFD_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LDFD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LDFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ldfd_pkg.sv @@
`timescale 1ns / 1ps

package ldfd_pkg;

	// Result event codes.
	typedef enum logic [1:0] {
		EV_DATA  = 2'd0,
		EV_EMPTY = 2'd1,
		EV_ERROR = 2'd2
	} event_t;

	// Completion status codes.
	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_TIMEOUT  = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_PREFIX   = 3'd3,
		ST_LINK     = 3'd4,
		ST_LENGTH   = 3'd5
	} status_t;

	// Configuration register indexes.
	localparam logic CFG_TIMEOUT  = 1'b0;
	localparam logic CFG_CAPACITY = 1'b1;

	// Register reset values.
	localparam logic [15:0] TIMEOUT_RESET  = 16'd0;
	localparam logic [15:0] CAPACITY_RESET = 16'd64;

	// Header layout: the fixed prefix, then the link digit, then a comma.
	localparam logic [15:0] PREFIX_LEN = 16'd7;
	localparam logic [15:0] LINK_POS   = 16'd7;
	localparam logic [15:0] COMMA_POS  = 16'd8;

	// Characters.
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] LEN_MAX = 16'hFFFF;

	// One result item.
	typedef struct packed {
		event_t      ev;
		logic [7:0]  data;
		logic        last;
		status_t     status;
		logic [2:0]  link;
		logic [15:0] len;
	} res_t;

	// Expected character of the fixed prefix CR LF "+IPD,".
	function automatic logic [7:0] prefix_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h0D;
			3'd1: ch = 8'h0A;
			3'd2: ch = 8'h2B;
			3'd3: ch = 8'h49;
			3'd4: ch = 8'h50;
			3'd5: ch = 8'h44;
			3'd6: ch = 8'h2C;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

@@ rtl/core/link_data_frame_deframer_unit.sv @@
// Link data frame deframer.
// Input channel (in_valid / in_stall): one request per cycle unless stalled,
// either a received byte (mode 0, rx_byte) or a one millisecond tick (mode 1).
// Output channel (out_valid / out_stall): result requests carrying event_res,
// data_byte, last, status, link_id and frame_length. A request gives zero, one
// or two results; two appear when a header byte is rejected and is rejected
// again when examined as the first byte of a new header.
// Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is
// the timeout in ticks (0 disables it), index 1 the header buffer capacity.
// cfg_ready is always high; write only while the block is idle.
// A request accepted into the input register is decoded from there, and its
// results are written into the result queue, from which they are taken.
// Throughput: one request per cycle, set by the single decode stage; a result
// queue of QUEUE_DEPTH entries takes the results, and a request waits in the
// input register while the queue lacks room for two results.
// Reset clears the frame state, the queue and the input register and loads the
// register defaults. When the receiver stalls, results collect in the queue and
// a held request raises in_stall once over QUEUE_DEPTH-2 results are queued.
`timescale 1ns / 1ps

module link_data_frame_deframer_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [7:0]  rx_byte,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [7:0]  data_byte,
	output logic        last,
	output logic [2:0]  status,
	output logic [2:0]  link_id,
	output logic [15:0] frame_length,
	// Configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

`include "link_data_frame_deframer_unit_defines.svh"

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] ROOM_LIMIT = CW'(QUEUE_DEPTH - 2);
	localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

	// Configuration registers
	logic [15:0] timeout_q;
	logic [15:0] capacity_q;

	// Input register
	logic        valid_s1;
	logic        mode_s1;
	logic [7:0]  byte_s1;

	// Frame state
	logic        in_payload_q;
	logic [15:0] hdr_idx_q;
	logic [2:0]  link_q;
	logic [15:0] len_q;
	logic [15:0] cnt_q;
	logic [15:0] idle_q;

	// Result queue
	ldfd_pkg::res_t  queue_q [QUEUE_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   count_q;

	// Decode results
	logic            proc;
	logic            accept;
	logic            pop;
	logic            push0;
	logic            push1;
	ldfd_pkg::res_t  res0;
	ldfd_pkg::res_t  res1;
	logic            in_payload_n;
	logic [15:0]     hdr_idx_n;
	logic [2:0]      link_n;
	logic [15:0]     len_n;
	logic [15:0]     cnt_n;
	logic [15:0]     idle_n;

	// Decode helpers
	logic [15:0]     idle_inc;
	logic [15:0]     cnt_inc;
	logic [16:0]     idx_plus1;
	logic [19:0]     len_acc;
	logic            is_digit;
	logic            hdr_fail;
	ldfd_pkg::status_t fail_status;
	logic [PW-1:0]   wptr_p1;
	logic [PW-1:0]   wptr_p2;
	logic [PW-1:0]   rptr_p1;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == LAST_SLOT) ? '0 : p + 1'b1;
	endfunction

	// Handshake
	assign cfg_ready = 1'b1;
	assign proc      = valid_s1 && (count_q <= ROOM_LIMIT);
	assign in_stall  = valid_s1 && !proc;
	assign accept    = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q  <= ldfd_pkg::TIMEOUT_RESET;
			capacity_q <= ldfd_pkg::CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ldfd_pkg::CFG_TIMEOUT:  timeout_q  <= cfg_data;
				ldfd_pkg::CFG_CAPACITY: capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || in_stall;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_s1 <= mode;
			byte_s1 <= rx_byte;
		end
	end

	// Header byte checks for the current position.
	always_comb begin
		idx_plus1 = {1'b0, hdr_idx_q} + 17'd1;
		len_acc   = {len_q, 3'b000} + {2'b00, len_q, 1'b0}
			+ {12'd0, byte_s1 - ldfd_pkg::CH_ZERO};
		is_digit  = (byte_s1 >= ldfd_pkg::CH_ZERO) && (byte_s1 <= ldfd_pkg::CH_NINE);
		hdr_fail  = 1'b0;
		fail_status = ldfd_pkg::ST_OK;
		if (idx_plus1 >= {1'b0, capacity_q}) begin
			hdr_fail    = 1'b1;
			fail_status = ldfd_pkg::ST_OVERFLOW;
		end else if (hdr_idx_q < ldfd_pkg::PREFIX_LEN) begin
			if (byte_s1 != ldfd_pkg::prefix_char(hdr_idx_q[2:0])) begin
				hdr_fail    = 1'b1;
				fail_status = ldfd_pkg::ST_PREFIX;
			end
		end else if (hdr_idx_q == ldfd_pkg::LINK_POS) begin
			if (byte_s1 < ldfd_pkg::CH_ZERO || byte_s1 > ldfd_pkg::CH_FOUR) begin
				hdr_fail    = 1'b1;
				fail_status = ldfd_pkg::ST_LINK;
			end
		end else if (hdr_idx_q == ldfd_pkg::COMMA_POS) begin
			if (byte_s1 != ldfd_pkg::CH_COMMA) begin
				hdr_fail    = 1'b1;
				fail_status = ldfd_pkg::ST_PREFIX;
			end
		end else if (!is_digit && byte_s1 != ldfd_pkg::CH_COLON) begin
			hdr_fail    = 1'b1;
			fail_status = ldfd_pkg::ST_LENGTH;
		end
	end

	// Next state and results for the request in the input register.
	always_comb begin
		in_payload_n = in_payload_q;
		hdr_idx_n    = hdr_idx_q;
		link_n       = link_q;
		len_n        = len_q;
		cnt_n        = cnt_q;
		idle_n       = idle_q;
		push0        = 1'b0;
		push1        = 1'b0;
		res0         = '0;
		res1         = '0;
		idle_inc     = (idle_q == ldfd_pkg::LEN_MAX) ? idle_q : idle_q + 16'd1;
		cnt_inc      = cnt_q + 16'd1;

		if (mode_s1) begin
			// Tick: count idle time and check the timeout.
			if (timeout_q != 16'd0 && idle_inc >= timeout_q) begin
				push0       = 1'b1;
				res0.ev     = ldfd_pkg::EV_ERROR;
				res0.last   = 1'b1;
				res0.status = ldfd_pkg::ST_TIMEOUT;
				in_payload_n = 1'b0;
				hdr_idx_n    = '0;
				link_n       = '0;
				len_n        = '0;
				cnt_n        = '0;
				idle_n       = '0;
			end else begin
				idle_n = idle_inc;
			end
		end else if (in_payload_q) begin
			// Payload byte: pass it on, closing the frame on the final one.
			push0     = 1'b1;
			res0.ev   = ldfd_pkg::EV_DATA;
			res0.data = byte_s1;
			if (cnt_inc >= len_q) begin
				res0.last    = 1'b1;
				res0.link    = link_q;
				res0.len     = len_q;
				in_payload_n = 1'b0;
				hdr_idx_n    = '0;
				link_n       = '0;
				len_n        = '0;
				cnt_n        = '0;
				idle_n       = '0;
			end else begin
				cnt_n = cnt_inc;
			end
		end else if (hdr_fail) begin
			// Rejected header byte: report and rearm.
			push0        = 1'b1;
			res0.ev      = ldfd_pkg::EV_ERROR;
			res0.last    = 1'b1;
			res0.status  = fail_status;
			in_payload_n = 1'b0;
			hdr_idx_n    = '0;
			link_n       = '0;
			len_n        = '0;
			cnt_n        = '0;
			idle_n       = '0;
			// A byte rejected past the first position is examined again as a
			// header start on the rearmed state.
			if (hdr_idx_q != 16'd0) begin
				if (capacity_q <= 16'd1) begin
					push1       = 1'b1;
					res1.ev     = ldfd_pkg::EV_ERROR;
					res1.last   = 1'b1;
					res1.status = ldfd_pkg::ST_OVERFLOW;
				end else if (byte_s1 != ldfd_pkg::CH_CR) begin
					push1       = 1'b1;
					res1.ev     = ldfd_pkg::EV_ERROR;
					res1.last   = 1'b1;
					res1.status = ldfd_pkg::ST_PREFIX;
				end else begin
					hdr_idx_n = 16'd1;
				end
			end
		end else if (hdr_idx_q > ldfd_pkg::COMMA_POS && byte_s1 == ldfd_pkg::CH_COLON) begin
			// Closing colon: an empty frame completes at once, else payload starts.
			if (len_q == 16'd0) begin
				push0        = 1'b1;
				res0.ev      = ldfd_pkg::EV_EMPTY;
				res0.last    = 1'b1;
				res0.link    = link_q;
				in_payload_n = 1'b0;
				hdr_idx_n    = '0;
				link_n       = '0;
				len_n        = '0;
				cnt_n        = '0;
				idle_n       = '0;
			end else begin
				in_payload_n = 1'b1;
				cnt_n        = '0;
				hdr_idx_n    = '0;
			end
		end else begin
			// Accepted header byte: advance and restart the idle count.
			if (hdr_idx_q == ldfd_pkg::LINK_POS) begin
				link_n = 3'(byte_s1 - ldfd_pkg::CH_ZERO);
			end else if (hdr_idx_q > ldfd_pkg::COMMA_POS) begin
				len_n = (len_acc > 20'h0FFFF) ? ldfd_pkg::LEN_MAX : len_acc[15:0];
			end
			hdr_idx_n = idx_plus1[15:0];
			idle_n    = '0;
		end
	end

	// Frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_idx_q    <= '0;
			link_q       <= '0;
			len_q        <= '0;
			cnt_q        <= '0;
			idle_q       <= '0;
		end else if (proc) begin
			in_payload_q <= in_payload_n;
			hdr_idx_q    <= hdr_idx_n;
			link_q       <= link_n;
			len_q        <= len_n;
			cnt_q        <= cnt_n;
			idle_q       <= idle_n;
		end
	end

	// Result queue pointers
	assign wptr_p1 = ptr_inc(wptr_q);
	assign wptr_p2 = ptr_inc(wptr_p1);
	assign rptr_p1 = ptr_inc(rptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (proc && push1) begin
				wptr_q <= wptr_p2;
			end else if (proc && push0) begin
				wptr_q <= wptr_p1;
			end
			if (pop) begin
				rptr_q <= rptr_p1;
			end
			count_q <= count_q + CW'(proc && push0) + CW'(proc && push1) - CW'(pop);
		end
	end

	// Result queue storage
	always_ff @(posedge clk) begin
		if (proc && push0) begin
			queue_q[wptr_q] <= res0;
		end
		if (proc && push1) begin
			queue_q[wptr_p1] <= res1;
		end
	end

	// Output fields
	assign event_res    = queue_q[rptr_q].ev;
	assign data_byte    = queue_q[rptr_q].data;
	assign last         = queue_q[rptr_q].last;
	assign status       = queue_q[rptr_q].status;
	assign link_id      = queue_q[rptr_q].link;
	assign frame_length = queue_q[rptr_q].len;

	// Checks
	`LDFD_ASSERT_ALWAYS(a_queue_bound, count_q <= FULL_COUNT, "result queue overrun")
	`LDFD_ASSERT_IMPL(a_payload_index, in_payload_q,
		hdr_idx_q == 16'd0 && len_q != 16'd0, "bad payload phase entry")
	`LDFD_ASSERT_IMPL(a_payload_count, in_payload_q, cnt_q < len_q, "payload count too high")
	`LDFD_ASSERT_NEXT(a_held_request, valid_s1 && !proc,
		valid_s1 && $stable(byte_s1) && $stable(mode_s1), "held request lost")

endmodule
